// ----- src/convex_polygon_overlap_test_assert.svh -----
// Assertion macros for the convex polygon overlap test.
`ifndef CONVEX_POLYGON_OVERLAP_TEST_ASSERT_SVH
`define CONVEX_POLYGON_OVERLAP_TEST_ASSERT_SVH
`ifndef SYNTH
`define CPOT_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CPOT_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CPOT_ASSERT_SAME(lbl, ck, rs, ante, cons)
`define CPOT_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

// ----- src/cpot_pkg.sv -----
// Shared types and constants of the convex polygon overlap test.
package cpot_pkg;
  localparam int CNT_W  = 6;
  localparam int ADDR_W = 5;

  typedef struct packed {
    logic [CNT_W-1:0] n1;
    logic [CNT_W-1:0] n2;
  } job_t;

  typedef struct packed {
    logic              sel;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef enum logic [3:0] {
    B_IDLE, B_RD_I, B_RD_J, B_EDGE, B_SQ, B_L2, B_ROOT, B_UNIT,
    B_PROJ, B_CMP, B_NEXT, B_DONE
  } back_state_t;
endpackage

// ----- src/cpot_if.sv -----
// Handshake channels for vertex requests and test results.
interface cpot_vtx_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [15:0] vert_x;
  logic signed [15:0] vert_y;
  logic               last_vertex;
  modport source (output valid, cmd, vert_x, vert_y, last_vertex, input ready);
  modport sink (input valid, cmd, vert_x, vert_y, last_vertex, output ready);
endinterface

interface cpot_res_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic [30:0]        depth;
  modport source (output valid, hit, axis_x, axis_y, depth, input ready);
  modport sink (input valid, hit, axis_x, axis_y, depth, output ready);
endinterface

// ----- src/cpot_front.sv -----
// Front end: takes vertex requests, stores both polygons and launches tests.
module cpot_front import cpot_pkg::*; #(
  parameter int MAX_VERTICES = 8
) (
  input  logic         clk,
  input  logic         rst,
  cpot_vtx_if.sink     vtx,
  output logic         job_valid,
  input  logic         job_ready,
  output job_t         job,
  input  logic         job_done,
  input  rd_req_t      rd_req,
  output logic [31:0]  rd_data
);
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [31:0]   first_mem [MAX_VERTICES];
  logic [31:0]   second_mem [MAX_VERTICES];
  logic [CW-1:0] first_count, second_count;
  logic [CW-1:0] fc_base, sc_base, first_count_next, second_count_next;
  logic          first_closed, second_closed, busy;
  logic          acc;
  logic [31:0]   word;

  assign vtx.ready = !busy && job_ready;
  assign acc = vtx.valid && vtx.ready;
  assign word = {vtx.vert_y, vtx.vert_x};

  always_comb begin
    fc_base = first_closed ? '0 : first_count;
    sc_base = second_closed ? '0 : second_count;
    first_count_next = (fc_base < CW'(MAX_VERTICES)) ? fc_base + 1'b1 : fc_base;
    second_count_next = (sc_base < CW'(MAX_VERTICES)) ? sc_base + 1'b1 : sc_base;
    job_valid = acc && vtx.cmd && vtx.last_vertex;
    job.n1 = CNT_W'(first_count);
    job.n2 = CNT_W'(second_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_count <= '0;
      second_count <= '0;
      first_closed <= 1'b0;
      second_closed <= 1'b0;
      busy <= 1'b0;
    end else begin
      if (acc && !vtx.cmd) begin
        first_count <= first_count_next;
        first_closed <= vtx.last_vertex;
      end
      if (acc && vtx.cmd) begin
        second_count <= second_count_next;
        second_closed <= vtx.last_vertex;
      end
      if (job_valid) begin
        busy <= 1'b1;
      end else if (job_done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !vtx.cmd && fc_base < CW'(MAX_VERTICES)) begin
      first_mem[fc_base[AW-1:0]] <= word;
    end
    if (acc && vtx.cmd && sc_base < CW'(MAX_VERTICES)) begin
      second_mem[sc_base[AW-1:0]] <= word;
    end
    rd_data <= rd_req.sel ? second_mem[rd_req.addr[AW-1:0]] : first_mem[rd_req.addr[AW-1:0]];
  end
endmodule

// ----- src/cpot_queue.sv -----
// Two-entry queue of test requests between the front and back ends.
module cpot_queue import cpot_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);
  job_t       slots [2];
  logic       wptr, rptr;
  logic [1:0] fill;
  logic       do_push, do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid = (fill != 2'd0);
  assign pop_job = slots[rptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= '0;
    end else begin
      if (do_push) wptr <= !wptr;
      if (do_pop) rptr <= !rptr;
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= push_job;
  end
endmodule

// ----- src/cpot_back.sv -----
// Back end: walks the edges, normalizes each axis, projects and keeps the best.
module cpot_back import cpot_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         job_valid,
  output logic         job_ready,
  input  job_t         job,
  output logic         job_done,
  output rd_req_t      rd_req,
  input  logic [31:0]  rd_data,
  cpot_res_if.source   res
);
  localparam int PW = 67;

  back_state_t state, state_next;
  logic [CNT_W-1:0] n1, n2, ei, k, n_cur, n_proj, j_idx;
  logic             poly, ppoly, v1, v2, first, any, gap;
  logic signed [15:0] vi_x, vi_y, rd_x, rd_y, nx, ny;
  logic signed [16:0] ex, ey;
  logic signed [33:0] exw, eyw;
  logic [33:0]        sqx, sqy, l2;
  logic [PW-1:0]      px, py, qx, qy, trial_x, trial_y, ax, ay, l2w;
  logic [15:0]        xx, xy;
  logic [3:0]         bitc;
  logic [16:0]        mx_u, my_u;
  logic signed [31:0] prodx, prody;
  logic signed [32:0] p, mn, mx, mn1, mx1;
  logic signed [33:0] d1, d2, d, best;
  logic signed [15:0] bx, by;
  logic               issue, out_free;

  assign rd_x = rd_data[15:0];
  assign rd_y = rd_data[31:16];
  assign n_cur = poly ? n2 : n1;
  assign n_proj = ppoly ? n2 : n1;
  assign j_idx = (ei + 1'b1 == n_cur) ? '0 : ei + 1'b1;
  assign issue = (k < n_proj);
  assign out_free = !res.valid || res.ready;
  assign exw = 34'(ex);
  assign eyw = 34'(ey);
  assign l2w = PW'(l2);
  assign ax = PW'({sqy, 30'b0});
  assign ay = PW'({sqx, 30'b0});
  assign trial_x = px + (qx << (bitc + 1'b1)) + (l2w << {bitc, 1'b0});
  assign trial_y = py + (qy << (bitc + 1'b1)) + (l2w << {bitc, 1'b0});
  assign mx_u = ({1'b0, xx} + 17'd1) >> 1;
  assign my_u = ({1'b0, xy} + 17'd1) >> 1;
  assign p = 33'(prodx) + 33'(prody);
  assign d1 = 34'(mx1) - 34'(mn);
  assign d2 = 34'(mx) - 34'(mn1);
  assign d = (d1 < d2) ? d1 : d2;

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    job_ready = 1'b0;
    job_done = 1'b0;
    rd_req.sel = poly;
    rd_req.addr = ADDR_W'(ei);
    case (state)
      B_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          state_next = (job.n1 == '0 || job.n2 == '0) ? B_DONE : B_RD_I;
        end
      end
      B_RD_I: state_next = B_RD_J;
      B_RD_J: begin
        rd_req.addr = ADDR_W'(j_idx);
        state_next = B_EDGE;
      end
      B_EDGE: state_next = B_SQ;
      B_SQ: state_next = (ex == '0 && ey == '0) ? B_NEXT : B_L2;
      B_L2: state_next = B_ROOT;
      B_ROOT: if (bitc == 4'd0) state_next = B_UNIT;
      B_UNIT: state_next = B_PROJ;
      B_PROJ: begin
        rd_req.sel = ppoly;
        rd_req.addr = ADDR_W'(k);
        if (!issue && !v1 && !v2 && ppoly) state_next = B_CMP;
      end
      B_CMP: begin
        if (mn > mx1 || mn1 > mx) state_next = B_DONE;
        else state_next = B_NEXT;
      end
      B_NEXT: begin
        if (ei + 1'b1 == n_cur && poly) state_next = B_DONE;
        else state_next = B_RD_I;
      end
      B_DONE: begin
        if (out_free) begin
          job_done = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        n1 <= job.n1;
        n2 <= job.n2;
        poly <= 1'b0;
        ei <= '0;
        any <= 1'b0;
        gap <= 1'b0;
      end
      B_RD_J: begin
        vi_x <= rd_x;
        vi_y <= rd_y;
      end
      B_EDGE: begin
        ex <= 17'(vi_x) - 17'(rd_x);
        ey <= 17'(vi_y) - 17'(rd_y);
      end
      B_SQ: begin
        sqx <= unsigned'(exw * exw);
        sqy <= unsigned'(eyw * eyw);
      end
      B_L2: begin
        l2 <= sqx + sqy;
        px <= '0;
        py <= '0;
        qx <= '0;
        qy <= '0;
        xx <= '0;
        xy <= '0;
        bitc <= 4'd15;
      end
      B_ROOT: begin
        if (trial_x <= ax) begin
          px <= trial_x;
          qx <= qx + (l2w << bitc);
          xx[bitc] <= 1'b1;
        end
        if (trial_y <= ay) begin
          py <= trial_y;
          qy <= qy + (l2w << bitc);
          xy[bitc] <= 1'b1;
        end
        bitc <= bitc - 1'b1;
      end
      B_UNIT: begin
        nx <= ey[16] ? -16'(mx_u) : 16'(mx_u);
        ny <= (!ex[16] && ex != '0) ? -16'(my_u) : 16'(my_u);
        ppoly <= 1'b0;
        k <= '0;
        v1 <= 1'b0;
        v2 <= 1'b0;
        first <= 1'b1;
      end
      B_PROJ: begin
        if (issue) k <= k + 1'b1;
        v1 <= issue;
        v2 <= v1;
        if (v1) begin
          prodx <= 32'(rd_x) * 32'(nx);
          prody <= 32'(rd_y) * 32'(ny);
        end
        if (v2) begin
          if (first || p < mn) mn <= p;
          if (first || p > mx) mx <= p;
          first <= 1'b0;
        end
        if (!issue && !v1 && !v2 && !ppoly) begin
          mn1 <= mn;
          mx1 <= mx;
          ppoly <= 1'b1;
          k <= '0;
          first <= 1'b1;
        end
      end
      B_CMP: begin
        if (mn > mx1 || mn1 > mx) begin
          gap <= 1'b1;
        end else if (!any || d <= best) begin
          best <= d;
          bx <= nx;
          by <= ny;
          any <= 1'b1;
        end
      end
      B_NEXT: begin
        if (ei + 1'b1 == n_cur) begin
          poly <= 1'b1;
          ei <= '0;
        end else begin
          ei <= ei + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (job_done) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_done) begin
      res.hit <= any && !gap;
      res.axis_x <= (any && !gap) ? bx : '0;
      res.axis_y <= (any && !gap) ? by : '0;
      if (!any || gap) res.depth <= '0;
      else if (best > 34'sh7FFFFFFF) res.depth <= '1;
      else res.depth <= best[30:0];
    end
  end
endmodule

// ----- src/convex_polygon_overlap_test.sv -----
// Convex polygon overlap test, separating axis theorem over both edge sets.
// A vertex request is taken when valid and ready are both high; the request closing the second polygon
// starts a test and holds off further requests until the result is loaded.
// Each edge of non-zero length runs the 16-step square-root loop and then projects both
// polygons, one projection per cycle; a zero-length edge skips both.
// Reset empties both polygons.
`include "convex_polygon_overlap_test_assert.svh"
module convex_polygon_overlap_test import cpot_pkg::*; #(
  parameter int MAX_VERTICES = 8
) (
  input logic        clk,
  input logic        rst,
  cpot_vtx_if.sink   vtx,
  cpot_res_if.source res
);
  logic    push_valid, push_ready, pop_valid, pop_ready, job_done;
  job_t    push_job, pop_job;
  rd_req_t rd_req;
  logic [31:0] rd_data;

  cpot_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk(clk), .rst(rst), .vtx(vtx),
    .job_valid(push_valid), .job_ready(push_ready), .job(push_job),
    .job_done(job_done), .rd_req(rd_req), .rd_data(rd_data)
  );

  cpot_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready), .push_job(push_job),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_job(pop_job)
  );

  cpot_back u_back (
    .clk(clk), .rst(rst),
    .job_valid(pop_valid), .job_ready(pop_ready), .job(pop_job),
    .job_done(job_done), .rd_req(rd_req), .rd_data(rd_data), .res(res)
  );

  `CPOT_ASSERT_SAME(a_launch, clk, rst, vtx.valid && vtx.ready && vtx.cmd && vtx.last_vertex, push_valid)
  `CPOT_ASSERT_NEXT(a_hold, clk, rst, push_valid, !vtx.ready)
  `CPOT_ASSERT_NEXT(a_result, clk, rst, job_done, res.valid)
  `CPOT_ASSERT_SAME(a_no_overwrite, clk, rst, job_done, !res.valid || res.ready)
endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the convex polygon overlap test: random polygons checked against a predictor.
module tb_top;
  import cpot_pkg::*;

  localparam int MAXV = 8;

  typedef struct packed {
    logic        hit;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [30:0] depth;
  } outcome_t;

  class overlap_scoreboard;
    logic [31:0] poly_a [MAXV];
    logic [31:0] poly_b [MAXV];
    int unsigned cnt_a, cnt_b;
    bit closed_a, closed_b;
    outcome_t pending_q[$];
    int errors;
    int checked;
    int hits;

    function new();
      cnt_a = 0; cnt_b = 0; closed_a = 0; closed_b = 0;
      errors = 0; checked = 0; hits = 0;
    endfunction

    function longint unit_len(longint unsigned a, longint unsigned l2);
      longint unsigned target, lo, hi, mid, t;
      target = (a * a) << 30;
      lo = 0; hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        t = 2 * mid - 1;
        if (t * t * l2 <= target) lo = mid;
        else hi = mid - 1;
      end
      return longint'(lo);
    endfunction

    function longint unit_part(longint c, longint unsigned l2);
      if (c < 0) return -unit_len(longint'(-c), l2);
      return unit_len(longint'(c), l2);
    endfunction

    function void span(bit sec, longint nx, longint ny, output longint mn, output longint mx);
      longint p;
      logic [31:0] w;
      int unsigned n;
      n = sec ? cnt_b : cnt_a;
      mn = 0; mx = 0;
      for (int k = 0; k < n; k++) begin
        w = sec ? poly_b[k] : poly_a[k];
        p = longint'($signed(w[15:0])) * nx + longint'($signed(w[31:16])) * ny;
        if (k == 0 || p < mn) mn = p;
        if (k == 0 || p > mx) mx = p;
      end
    endfunction

    function outcome_t collide();
      outcome_t r;
      longint best, bx, by, ex, ey, nx, ny, mn1, mx1, mn2, mx2, d;
      longint unsigned l2;
      logic [31:0] vi, vj;
      int unsigned n, j;
      bit any;
      r = '0;
      best = 64'sh7FFF_FFFF_FFFF_FFFF;
      bx = 0; by = 0; any = 0;
      if (cnt_a == 0 || cnt_b == 0) return r;
      for (int p = 0; p < 2; p++) begin
        n = p ? cnt_b : cnt_a;
        for (int i = 0; i < n; i++) begin
          j = (i + 1 == n) ? 0 : i + 1;
          vi = p ? poly_b[i] : poly_a[i];
          vj = p ? poly_b[j] : poly_a[j];
          ex = longint'($signed(vi[15:0])) - longint'($signed(vj[15:0]));
          ey = longint'($signed(vi[31:16])) - longint'($signed(vj[31:16]));
          if (ex == 0 && ey == 0) continue;
          l2 = longint'(ex * ex) + longint'(ey * ey);
          nx = unit_part(ey, l2);
          ny = unit_part(-ex, l2);
          span(0, nx, ny, mn1, mx1);
          span(1, nx, ny, mn2, mx2);
          if (mn2 > mx1 || mn1 > mx2) return r;
          d = (mx1 - mn2 < mx2 - mn1) ? mx1 - mn2 : mx2 - mn1;
          if (d <= best) begin
            best = d; bx = nx; by = ny;
          end
          any = 1;
        end
      end
      if (!any) return r;
      r.hit = 1;
      r.ax = bx[15:0];
      r.ay = by[15:0];
      r.depth = (best > 64'sh7FFF_FFFF) ? 31'h7FFF_FFFF : best[30:0];
      return r;
    endfunction

    function void note_vertex(bit sec, logic [15:0] x, logic [15:0] y, bit last);
      if (!sec) begin
        if (closed_a) begin cnt_a = 0; closed_a = 0; end
        if (cnt_a < MAXV) begin poly_a[cnt_a] = {y, x}; cnt_a++; end
        if (last) closed_a = 1;
        return;
      end
      if (closed_b) begin cnt_b = 0; closed_b = 0; end
      if (cnt_b < MAXV) begin poly_b[cnt_b] = {y, x}; cnt_b++; end
      if (last) begin
        closed_b = 1;
        pending_q.push_back(collide());
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result hit=%0d axis=(%0d,%0d) depth=%0d", $time,
                 got.hit, $signed(got.ax), $signed(got.ay), got.depth);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (want.hit) hits++;
      if (got.hit !== want.hit) begin
        $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
        errors++;
      end
      if (got.ax !== want.ax) begin
        $display("%0t: axis_x expected %0d actual %0d", $time, $signed(want.ax), $signed(got.ax));
        errors++;
      end
      if (got.ay !== want.ay) begin
        $display("%0t: axis_y expected %0d actual %0d", $time, $signed(want.ay), $signed(got.ay));
        errors++;
      end
      if (got.depth !== want.depth) begin
        $display("%0t: depth expected %0d actual %0d", $time, want.depth, got.depth);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  cpot_vtx_if vtx();
  cpot_res_if res();
  overlap_scoreboard sb;
  int sent;
  bit stim_done;
  int burst_left;

  convex_polygon_overlap_test #(.MAX_VERTICES(MAXV)) dut (
    .clk(clk), .rst(rst), .vtx(vtx), .res(res)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_vertex(bit sec, int x, int y, bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      vtx.valid = 0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    vtx.valid = 1;
    vtx.cmd = sec;
    vtx.vert_x = x[15:0];
    vtx.vert_y = y[15:0];
    vtx.last_vertex = last;
    do @(posedge clk); while (!vtx.ready);
    sb.note_vertex(sec, x[15:0], y[15:0], last);
    sent++;
    @(negedge clk);
    vtx.valid = 0;
  endtask

  task automatic send_poly(bit sec, int xs[], int ys[], bit close);
    for (int i = 0; i < xs.size(); i++)
      send_vertex(sec, xs[i], ys[i], close && i == xs.size() - 1);
  endtask

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic random_poly(bit sec, int cx, int cy, int rad, int n, bit close);
    int xs[], ys[];
    real step, ang;
    xs = new[n]; ys = new[n];
    step = 6.283185307 / n;
    ang = $urandom_range(0, 6283) / 1000.0;
    for (int i = 0; i < n; i++) begin
      ang += step * (0.6 + $urandom_range(0, 800) / 1000.0);
      xs[i] = clip16(cx + $rtoi(rad * $cos(ang)));
      ys[i] = clip16(cy + $rtoi(rad * $sin(ang)));
    end
    send_poly(sec, xs, ys, close);
  endtask

  function automatic int rnd16();
    return int'($signed(16'($urandom)));
  endfunction

  task automatic random_pair();
    int cx, cy, rad, sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      for (int i = $urandom_range(1, 6); i > 0; i--)
        send_vertex($urandom_range(0, 1), rnd16(), rnd16(), $urandom_range(0, 3) == 0);
      return;
    end
    rad = (sel == 1) ? $urandom_range(10000, 40000) : $urandom_range(2, 3000);
    cx = (sel == 1) ? 0 : $urandom_range(0, 60000) - 30000;
    cy = (sel == 1) ? 0 : $urandom_range(0, 60000) - 30000;
    if ($urandom_range(0, 2) != 0)
      random_poly(0, cx, cy, rad, $urandom_range(3, 9), $urandom_range(0, 7) != 0);
    random_poly(1, cx + $urandom_range(0, 2 * rad) - rad, cy + $urandom_range(0, 2 * rad) - rad,
                $urandom_range(1, rad + 1), $urandom_range(3, 10), 1);
  endtask

  initial begin
    sb = new();
    sent = 0;
    stim_done = 0;
    burst_left = 0;
    rst = 1;
    vtx.valid = 0; vtx.cmd = 0; vtx.vert_x = 0; vtx.vert_y = 0; vtx.last_vertex = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_poly(1, '{0, 10, 0}, '{0, 0, 10}, 1);
    send_poly(0, '{0, 100, 0}, '{0, 0, 100}, 1);
    send_poly(1, '{50, 150, 50}, '{50, 50, 150}, 1);
    send_poly(1, '{500, 600, 500}, '{500, 500, 600}, 1);
    send_poly(1, '{7, 7, 7}, '{7, 7, 7}, 1);
    send_poly(0, '{-32768, 32767, 32767, -32768}, '{-32768, -32768, 32767, 32767}, 1);
    send_poly(1, '{-32768, 32767, 32767, -32768, 0, 1, 2, 3, 4, 5},
              '{-32768, -32768, 32767, 32767, 0, 1, 2, 3, 4, 5}, 1);
    send_poly(0, '{0, 40, 40}, '{0, 0, 40}, 0);
    send_poly(1, '{10, 30, 30}, '{5, 5, 30}, 1);

    while (sent < 1800) begin
      random_pair();
      if ($urandom_range(0, 60) == 0 || (sent > 900 && sent < 920)) begin
        vtx.valid = 0;
        while (sb.pending_q.size() != 0) @(negedge clk);
      end
    end
    stim_done = 1;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (3000) @(negedge clk);
    $display("Checked %0d tests (%0d hits) from %0d vertex requests.", sb.checked, sb.hits, sent);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    int mode, hold;
    bit held;
    mode = 0; hold = 0; held = 0;
    res.ready = 0;
    forever begin
      @(negedge clk);
      if (!held && sb != null && sb.checked == 20) begin
        held = 1;
        hold = 4000;
      end
      if (hold > 0) begin
        hold--;
        res.ready = 0;
      end else begin
        mode = (mode + 1) % 400;
        if (mode < 150) res.ready = 1;
        else res.ready = ($urandom_range(0, 2) != 0);
      end
    end
  end

  always @(posedge clk) begin
    outcome_t got;
    if (!rst && res.valid && res.ready) begin
      got.hit = res.hit;
      got.ax = res.axis_x;
      got.ay = res.axis_y;
      got.depth = res.depth;
      sb.check_result(got);
    end
  end
endmodule

// ----- convex_polygon_overlap_test.f -----
+incdir+src
src/cpot_pkg.sv
src/cpot_if.sv
src/cpot_front.sv
src/cpot_queue.sv
src/cpot_back.sv
src/convex_polygon_overlap_test.sv
tb/sv/tb_top.sv
